// ===== hw/rtl/clamped_integer_entry_macros.svh =====
// Assertion macros shared by the clamped integer entry RTL.
`ifndef CLAMPED_INTEGER_ENTRY_MACROS_SVH
`define CLAMPED_INTEGER_ENTRY_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk, quiet while arst_n is low
`define CIE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, quiet while arst_n is low
`define CIE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CIE_ASSERT_SAME(lbl, ante, cons, msg)
`define CIE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/cie_pkg.sv =====
// Shared types, operation codes and character constants for the clamped integer entry.
`timescale 1ns / 1ps
`default_nettype none
package cie_pkg;

	localparam int VALUE_W = 32;
	localparam int STEP_W  = 31;
	localparam int OP_W    = 3;
	localparam int CHAR_W  = 8;
	localparam int CFG_IDX_W = 2;

	// Operation codes
	localparam logic [OP_W-1:0] OP_TEXT      = 3'd0;
	localparam logic [OP_W-1:0] OP_STEP_UP   = 3'd1;
	localparam logic [OP_W-1:0] OP_STEP_DOWN = 3'd2;
	localparam logic [OP_W-1:0] OP_SET       = 3'd3;
	localparam logic [OP_W-1:0] OP_SLIDER    = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 2'd2;

	// Character constants
	localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
	localparam logic [CHAR_W-1:0] CASE_MASK = 8'hDF;
	localparam logic [CHAR_W-1:0] DEC_RADIX = 8'd10;

	// Bounds used when min >= max
	localparam logic signed [VALUE_W-1:0] FULL_LO = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] FULL_HI = 32'sh7FFF_FFFF;

	// Parser view handed to the value unit
	typedef struct packed {
		logic               done;
		logic [VALUE_W-1:0] word;
	} txt_t;

	// Outcome of one transaction
	typedef struct packed {
		logic                      emit;
		logic                      notify;
		logic signed [VALUE_W-1:0] value;
	} res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/clamped_integer_entry.sv =====
// Clamped integer entry: transaction register, state, result register and checks.
//
// Holds one signed 32-bit value kept within [min_value, max_value] (full range when
// min_value >= max_value), driven by text characters, step up/down, direct set and
// slider position. One transaction is taken per clock cycle, back to back, unless the
// input side stalls: an accepted item is registered in the input register, where the
// parser and the value unit work on it against the held state in a single pass, and
// its result (if any) is registered in the output register as the item advances. Only the final
// character of a text and the non-text operations produce a result; codes five to
// seven are dropped. The input side stalls only while a result waits in the output
// register, is not taken in that cycle, and the item in the input register would
// produce another. Configuration writes are always ready and must be issued while
// the block is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "clamped_integer_entry_macros.svh"
module clamped_integer_entry (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Input transactions
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [cie_pkg::OP_W-1:0]            operation,
	input  wire logic [cie_pkg::CHAR_W-1:0]          character,
	input  wire logic                                last_char,
	input  wire logic signed [cie_pkg::VALUE_W-1:0]  operand,
	// Result transactions
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [cie_pkg::VALUE_W-1:0]       value,
	output logic                                     notify,
	// Configuration writes
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [cie_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [cie_pkg::VALUE_W-1:0]         cfg_data
);

	logic                                valid_s1;
	logic [cie_pkg::OP_W-1:0]            op_s1;
	logic [cie_pkg::CHAR_W-1:0]          char_s1;
	logic                                last_s1;
	logic signed [cie_pkg::VALUE_W-1:0]  operand_s1;

	logic signed [cie_pkg::VALUE_W-1:0]  min_q, max_q, held_q, value_q;
	logic [cie_pkg::STEP_W-1:0]          step_q;
	logic                                out_valid_q, notify_q;

	logic                                adv;
	logic                                parse_en;
	cie_pkg::txt_t                       txt;
	cie_pkg::res_t                       res;

	// Advance the held item unless its result would overwrite one still waiting
	assign adv      = valid_s1 && (!res.emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign parse_en = adv && (op_s1 == cie_pkg::OP_TEXT);
	assign cfg_ready = 1'b1;

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign notify    = notify_q;

	// Input register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1      <= operation;
			char_s1    <= character;
			last_s1    <= last_char;
			operand_s1 <= operand;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= cie_pkg::FULL_LO;
			max_q  <= cie_pkg::FULL_HI;
			step_q <= cie_pkg::STEP_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cie_pkg::REG_MIN_VALUE: min_q  <= $signed(cfg_data);
				cie_pkg::REG_MAX_VALUE: max_q  <= $signed(cfg_data);
				cie_pkg::REG_STEP_SIZE: step_q <= cfg_data[cie_pkg::STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	cie_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.enable    (parse_en),
		.character (char_s1),
		.last_char (last_s1),
		.txt       (txt)
	);

	cie_value u_value (
		.operation (op_s1),
		.operand   (operand_s1),
		.held      (held_q),
		.min_value (min_q),
		.max_value (max_q),
		.step_size (step_q),
		.txt       (txt),
		.res       (res)
	);

	// Held value and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv && res.emit) begin
				held_q      <= res.value;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (adv && res.emit) begin
			value_q  <= res.value;
			notify_q <= res.notify;
		end
	end

	// Checks
	`CIE_ASSERT_NEXT(a_held_only_on_result, !(adv && res.emit), $stable(held_q),
		"held value changed without a result")
	`CIE_ASSERT_SAME(a_no_overwrite, valid_s1 && !adv, !in_ready,
		"input accepted while the held item is stalled")
	`CIE_ASSERT_NEXT(a_result_matches_held, adv && res.emit, out_valid && (value == held_q),
		"result register disagrees with held value")

endmodule
`default_nettype wire

// ===== hw/rtl/cie_parser.sv =====
// Text parser: sign, hex or decimal digits, wrapping accumulator.
`timescale 1ns / 1ps
`default_nettype none
module cie_parser (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         enable,
	input  wire logic [cie_pkg::CHAR_W-1:0]   character,
	input  wire logic                         last_char,
	output cie_pkg::txt_t                     txt
);

	typedef enum logic [2:0] {
		PH_START,
		PH_MINUS,
		PH_ZERO,
		PH_HEX,
		PH_DEC,
		PH_STOP
	} phase_t;

	phase_t                         phase_q, phase_d;
	logic [cie_pkg::VALUE_W-1:0]    acc_q, acc_d;
	logic                           neg_q, neg_d;

	logic [cie_pkg::CHAR_W-1:0]     dec_x;
	logic                           dec_ok;
	logic [cie_pkg::VALUE_W-1:0]    acc_dec;
	logic [cie_pkg::VALUE_W-1:0]    acc_hex;
	logic                           hex_ok;
	logic [3:0]                     hex_val;
	logic                           lead;

	// Decimal digit: times ten as two shifts plus the digit
	assign dec_x   = character ^ cie_pkg::CH_ZERO;
	assign dec_ok  = dec_x < cie_pkg::DEC_RADIX;
	assign acc_dec = (acc_q << 3) + (acc_q << 1)
		+ {{(cie_pkg::VALUE_W-4){1'b0}}, dec_x[3:0]};

	// Hex digit decode
	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		if (character >= 8'h30 && character <= 8'h39) begin
			hex_val = 4'(character - 8'h30);
		end else if (character >= 8'h61 && character <= 8'h66) begin
			hex_val = 4'(character - 8'h57);
		end else if (character >= 8'h41 && character <= 8'h46) begin
			hex_val = 4'(character - 8'h37);
		end else begin
			hex_ok  = 1'b0;
		end
	end
	assign acc_hex = {acc_q[cie_pkg::VALUE_W-5:0], hex_val};

	// First character after an optional minus sign
	assign lead = (phase_q == PH_MINUS)
		|| (phase_q == PH_START && character != cie_pkg::CH_MINUS);

	// Next parser state
	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		case (phase_q)
			PH_START, PH_MINUS: begin
				if (!lead) begin
					neg_d   = 1'b1;
					phase_d = PH_MINUS;
				end else if (character == cie_pkg::CH_HASH) begin
					phase_d = PH_HEX;
				end else if (character == cie_pkg::CH_ZERO) begin
					phase_d = PH_ZERO;
				end else if (dec_ok) begin
					acc_d   = acc_dec;
					phase_d = PH_DEC;
				end else begin
					phase_d = PH_STOP;
				end
			end
			PH_ZERO: begin
				if ((character & cie_pkg::CASE_MASK) == cie_pkg::CH_UPPER_X) begin
					phase_d = PH_HEX;
				end else if (dec_ok) begin
					acc_d   = acc_dec;
					phase_d = PH_DEC;
				end else begin
					phase_d = PH_STOP;
				end
			end
			PH_HEX: begin
				if (hex_ok) begin
					acc_d = acc_hex;
				end else begin
					phase_d = PH_STOP;
				end
			end
			PH_DEC: begin
				if (dec_ok) begin
					acc_d = acc_dec;
				end else begin
					phase_d = PH_STOP;
				end
			end
			default: begin
			end
		endcase
	end

	// Finished word, negated when a minus sign was seen
	assign txt.done = last_char;
	assign txt.word = neg_d ? (~acc_d + 32'd1) : acc_d;

	// Hold parser state; return to start of text after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			acc_q   <= '0;
			neg_q   <= 1'b0;
		end else if (enable) begin
			if (last_char) begin
				phase_q <= PH_START;
				acc_q   <= '0;
				neg_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
				neg_q   <= neg_d;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/cie_value.sv =====
// Value unit: steps, set, slider and text result, clamped to the bounds.
`timescale 1ns / 1ps
`default_nettype none
module cie_value (
	input  wire logic [cie_pkg::OP_W-1:0]           operation,
	input  wire logic signed [cie_pkg::VALUE_W-1:0] operand,
	input  wire logic signed [cie_pkg::VALUE_W-1:0] held,
	input  wire logic signed [cie_pkg::VALUE_W-1:0] min_value,
	input  wire logic signed [cie_pkg::VALUE_W-1:0] max_value,
	input  wire logic [cie_pkg::STEP_W-1:0]         step_size,
	input  cie_pkg::txt_t                           txt,
	output cie_pkg::res_t                           res
);

	logic                              full;
	logic signed [cie_pkg::VALUE_W-1:0] lo, hi;
	logic signed [cie_pkg::VALUE_W:0]   lo_x, hi_x, held_x, step_x;
	logic signed [cie_pkg::VALUE_W:0]   up_sum, down_sum, slide_sum;
	logic signed [cie_pkg::VALUE_W-1:0] v;
	logic                               may_notify;

	function automatic logic signed [cie_pkg::VALUE_W-1:0] clamp_to(
		input logic signed [cie_pkg::VALUE_W:0]   x,
		input logic signed [cie_pkg::VALUE_W-1:0] lower,
		input logic signed [cie_pkg::VALUE_W-1:0] upper
	);
		logic signed [cie_pkg::VALUE_W-1:0] r;
		if (x > $signed({upper[cie_pkg::VALUE_W-1], upper})) begin
			r = upper;
		end else if (x < $signed({lower[cie_pkg::VALUE_W-1], lower})) begin
			r = lower;
		end else begin
			r = x[cie_pkg::VALUE_W-1:0];
		end
		return r;
	endfunction

	// Effective bounds: full range when min >= max
	assign full = min_value >= max_value;
	assign lo   = full ? cie_pkg::FULL_LO : min_value;
	assign hi   = full ? cie_pkg::FULL_HI : max_value;

	// Widened operands so sums never overflow
	assign lo_x      = $signed({lo[cie_pkg::VALUE_W-1], lo});
	assign hi_x      = $signed({hi[cie_pkg::VALUE_W-1], hi});
	assign held_x    = $signed({held[cie_pkg::VALUE_W-1], held});
	assign step_x    = $signed({2'b00, step_size});
	assign up_sum    = held_x + step_x;
	assign down_sum  = held_x - step_x;
	assign slide_sum = lo_x + $signed({operand[cie_pkg::VALUE_W-1], operand});

	// Select the new value per operation
	always_comb begin
		v          = held;
		may_notify = 1'b1;
		res.emit   = 1'b1;
		case (operation)
			cie_pkg::OP_TEXT: begin
				res.emit = txt.done;
				v = clamp_to($signed({txt.word[cie_pkg::VALUE_W-1], txt.word}), lo, hi);
			end
			cie_pkg::OP_STEP_UP: begin
				v = (up_sum > hi_x) ? hi : up_sum[cie_pkg::VALUE_W-1:0];
			end
			cie_pkg::OP_STEP_DOWN: begin
				v = (down_sum < lo_x) ? lo : down_sum[cie_pkg::VALUE_W-1:0];
			end
			cie_pkg::OP_SET: begin
				may_notify = 1'b0;
				v = clamp_to($signed({operand[cie_pkg::VALUE_W-1], operand}), lo, hi);
			end
			cie_pkg::OP_SLIDER: begin
				v = clamp_to(slide_sum, lo, hi);
			end
			default: begin
				res.emit = 1'b0;
			end
		endcase
		res.value  = v;
		res.notify = may_notify && (v != held);
	end

endmodule
`default_nettype wire
